[design/iadc_pkg.sv]
// Package for the integer ALU with divide check.
// Command and status codes plus the per-stage transaction record; no dependencies.
package iadc_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MOD = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_MOD_ZERO = 2'd2,
    ST_BAD_CMD  = 2'd3
  } status_e;

  // Control that rides along with each transaction through the divider cells.
  typedef struct packed {
    logic    vld;
    logic    is_div;  // divide or modulo: result comes from the cells
    logic    is_mod;
    logic    neg_q;
    logic    neg_r;
    status_e status;
  } ctl_t;

endpackage

[design/iadc_div_cell.sv]
// One restoring-division cell: resolves one quotient bit per transaction.
// Depends on iadc_pkg for the control record.
module iadc_div_cell #(
  parameter int W = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iadc_pkg::ctl_t  ctl_i,
  input  logic [W-1:0]    rem_i,   // partial remainder
  input  logic [W-1:0]    quo_i,   // dividend bits shifting out / quotient in
  input  logic [W-1:0]    den_i,
  input  logic [W-1:0]    res_i,   // non-divide result carried along
  output iadc_pkg::ctl_t  ctl_o,
  output logic [W-1:0]    rem_o,
  output logic [W-1:0]    quo_o,
  output logic [W-1:0]    den_o,
  output logic [W-1:0]    res_o
);

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] rem_d;

  always_comb begin
    trial = {rem_i, quo_i[W-1]};
    diff  = trial - {1'b0, den_i};
    take  = ~diff[W];
    rem_d = take ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    quo_o <= {quo_i[W-2:0], take};
    den_o <= den_i;
    res_o <= res_i;
  end

endmodule

[design/integer_alu_with_div_check_unit.sv]
// Signed integer ALU (add, sub, mul, div, mod) with divide-by-zero check.
// Every command passes the same registers in order: decode register, DATA_WIDTH
// divider cells, output register; result_valid_o rises out of the last.
// Throughput: one transaction per cycle; busy is tied low, the chain of
// DATA_WIDTH divider cells (one quotient bit each) sets the latency.
// Reset: asynchronous, active low; clears all valid bits, no result in flight.
// The receiver cannot stall; each result shows for exactly one cycle.
module integer_alu_with_div_check_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            command_i,
  input  logic [DATA_WIDTH-1:0] operand_a_i,
  input  logic [DATA_WIDTH-1:0] operand_b_i,
  output logic                  result_valid_o,
  output logic [DATA_WIDTH-1:0] result_o,
  output logic [1:0]            status_o
);

  localparam int W = DATA_WIDTH;

  assign busy = 1'b0;

  // ---- stage 0: decode, magnitudes, product register ----
  iadc_pkg::ctl_t ctl0_d, ctl0_q;
  logic [W-1:0]   a_mag, b_mag, res0_d;
  logic [W-1:0]   num0_q, den0_q, res0_q;
  logic [W-1:0]   prod_q;
  logic           is_mul_q;

  always_comb begin
    a_mag  = operand_a_i[W-1] ? (W'(0) - operand_a_i) : operand_a_i;
    b_mag  = operand_b_i[W-1] ? (W'(0) - operand_b_i) : operand_b_i;
    ctl0_d = '0;
    ctl0_d.vld    = start;
    ctl0_d.neg_q  = operand_a_i[W-1] ^ operand_b_i[W-1];
    ctl0_d.neg_r  = operand_a_i[W-1];
    ctl0_d.status = iadc_pkg::ST_OK;
    res0_d = '0;
    case (command_i)
      iadc_pkg::CMD_ADD: res0_d = operand_a_i + operand_b_i;
      iadc_pkg::CMD_SUB: res0_d = operand_a_i - operand_b_i;
      iadc_pkg::CMD_MUL: res0_d = '0;
      iadc_pkg::CMD_DIV: begin
        if (operand_b_i == '0) ctl0_d.status = iadc_pkg::ST_DIV_ZERO;
        else                   ctl0_d.is_div = 1'b1;
      end
      iadc_pkg::CMD_MOD: begin
        if (operand_b_i == '0) ctl0_d.status = iadc_pkg::ST_MOD_ZERO;
        else begin
          ctl0_d.is_div = 1'b1;
          ctl0_d.is_mod = 1'b1;
        end
      end
      default: ctl0_d.status = iadc_pkg::ST_BAD_CMD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= ctl0_d;
    end
  end

  // Product registered straight after the multiplier; merged next stage.
  always_ff @(posedge clk_i) begin
    num0_q   <= a_mag;
    den0_q   <= b_mag;
    res0_q   <= res0_d;
    prod_q   <= operand_a_i * operand_b_i;
    is_mul_q <= (command_i == iadc_pkg::CMD_MUL);
  end

  logic [W-1:0] res1;
  assign res1 = is_mul_q ? prod_q : res0_q;

  // ---- divider cell chain ----
  iadc_pkg::ctl_t ctl_c [W+1];
  logic [W-1:0]   rem_c [W+1];
  logic [W-1:0]   quo_c [W+1];
  logic [W-1:0]   den_c [W+1];
  logic [W-1:0]   res_c [W+1];

  assign ctl_c[0] = ctl0_q;
  assign rem_c[0] = '0;
  assign quo_c[0] = num0_q;
  assign den_c[0] = den0_q;
  assign res_c[0] = res1;

  for (genvar g = 0; g < W; g++) begin : g_cell
    iadc_div_cell #(.W(W)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_c[g]),
      .rem_i (rem_c[g]),
      .quo_i (quo_c[g]),
      .den_i (den_c[g]),
      .res_i (res_c[g]),
      .ctl_o (ctl_c[g+1]),
      .rem_o (rem_c[g+1]),
      .quo_o (quo_c[g+1]),
      .den_o (den_c[g+1]),
      .res_o (res_c[g+1])
    );
  end

  // ---- output stage: sign fix-up and zeroing on error ----
  iadc_pkg::ctl_t ctl_l;
  logic [W-1:0]   q_l, r_l, out_d;
  logic           vld_q;
  logic [W-1:0]   res_q;
  logic [1:0]     st_q;

  always_comb begin
    ctl_l = ctl_c[W];
    q_l   = ctl_l.neg_q ? (W'(0) - quo_c[W]) : quo_c[W];
    r_l   = ctl_l.neg_r ? (W'(0) - rem_c[W]) : rem_c[W];
    if (ctl_l.status != iadc_pkg::ST_OK) out_d = '0;
    else if (ctl_l.is_mod)               out_d = r_l;
    else if (ctl_l.is_div)               out_d = q_l;
    else                                 out_d = res_c[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_l.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= out_d;
    st_q  <= ctl_l.status;
  end

  assign result_valid_o = vld_q;
  assign result_o       = res_q;
  assign status_o       = st_q;

  // ---- assertions ----
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != iadc_pkg::ST_OK) |-> (result_o == '0))
    else $error("nonzero result with error status");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl0_q.vld) |-> ##(W+1) result_valid_o)
    else $error("transaction lost in cell chain");

  a_div_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl0_q.vld && ctl0_q.is_div) |-> (ctl0_q.status == iadc_pkg::ST_OK))
    else $error("divide path taken with error status");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl0_q.vld && ctl0_q.is_div) |-> (den0_q != '0))
    else $error("zero divisor entered cell chain");

endmodule

[test/tb_integer_alu_with_div_check_unit.sv]
// Testbench for the integer ALU with divide check: directed corner cases, then
// random commands under several idle patterns, each result checked in order.
// Depends on iadc_pkg and integer_alu_with_div_check_unit.
module tb_integer_alu_with_div_check_unit;

  localparam int W = 32;
  localparam int LATENCY = W + 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_ONE = '1;

  typedef struct {
    logic [W-1:0]      value;
    iadc_pkg::status_e status;
  } alu_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [2:0]   command_i = '0;
  logic [W-1:0] operand_a_i = '0;
  logic [W-1:0] operand_b_i = '0;
  logic         result_valid_o;
  logic [W-1:0] result_o;
  logic [1:0]   status_o;

  alu_result_t pending_results[$];
  int          error_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;  // chance of an idle cycle before each transaction

  integer_alu_with_div_check_unit #(.DATA_WIDTH(W)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .status_o      (status_o)
  );

  always #2 clk_i = ~clk_i;

  // Expected result of one transaction. Division works on magnitudes, then
  // fixes the sign: quotient negative when signs differ, remainder follows
  // the dividend. MIN / -1 falls out as MIN with remainder 0 by wrapping.
  function automatic alu_result_t compute_alu(logic [2:0] cmd, logic [W-1:0] a,
                                               logic [W-1:0] b);
    alu_result_t  r;
    logic [W-1:0] mag_a, mag_b, q, rem;
    mag_a = a[W-1] ? -a : a;
    mag_b = b[W-1] ? -b : b;
    r.value = '0;
    r.status = iadc_pkg::ST_OK;
    case (cmd)
      iadc_pkg::CMD_ADD: r.value = a + b;
      iadc_pkg::CMD_SUB: r.value = a - b;
      iadc_pkg::CMD_MUL: r.value = a * b;
      iadc_pkg::CMD_DIV, iadc_pkg::CMD_MOD: begin
        if (b == '0) begin
          if (cmd == iadc_pkg::CMD_DIV) r.status = iadc_pkg::ST_DIV_ZERO;
          else r.status = iadc_pkg::ST_MOD_ZERO;
        end else begin
          q = mag_a / mag_b;
          rem = mag_a % mag_b;
          if (cmd == iadc_pkg::CMD_DIV) r.value = (a[W-1] != b[W-1]) ? -q : q;
          else r.value = a[W-1] ? -rem : rem;
        end
      end
      default: r.status = iadc_pkg::ST_BAD_CMD;
    endcase
    return r;
  endfunction

  // Drive one transaction and hold start until it is taken. Start stays high
  // across back-to-back transactions, dropping only for an idle cycle.
  task automatic send_op(logic [2:0] cmd, logic [W-1:0] a, logic [W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(compute_alu(cmd, a, b));
    sent_count++;
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off until every outstanding transaction has returned.
  task automatic drain();
    go_quiet();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Operand biased toward corners so wraps and sign cases show up often.
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return MIN_VAL;
      1: return MAX_VAL;
      2: return NEG_ONE;
      3: return '0;
      4: return W'($urandom_range(8)) - W'(4);
      5: return {$urandom()} >> $urandom_range(W-1);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_op(iadc_pkg::CMD_ADD, MAX_VAL, W'(1));    // add overflow
    send_op(iadc_pkg::CMD_ADD, MIN_VAL, NEG_ONE);
    send_op(iadc_pkg::CMD_ADD, NEG_ONE, NEG_ONE);
    send_op(iadc_pkg::CMD_SUB, MIN_VAL, W'(1));    // subtract overflow
    send_op(iadc_pkg::CMD_SUB, '0, MIN_VAL);
    send_op(iadc_pkg::CMD_SUB, W'(5), W'(9));
    send_op(iadc_pkg::CMD_MUL, MAX_VAL, MAX_VAL);
    send_op(iadc_pkg::CMD_MUL, MIN_VAL, NEG_ONE);
    send_op(iadc_pkg::CMD_MUL, W'(-7), W'(6));
    send_op(iadc_pkg::CMD_DIV, MIN_VAL, NEG_ONE);  // quotient wraps back to MIN
    send_op(iadc_pkg::CMD_MOD, MIN_VAL, NEG_ONE);
    send_op(iadc_pkg::CMD_DIV, W'(7), W'(-2));     // truncation toward zero
    send_op(iadc_pkg::CMD_DIV, W'(-7), W'(2));
    send_op(iadc_pkg::CMD_MOD, W'(-7), W'(2));     // remainder takes dividend sign
    send_op(iadc_pkg::CMD_MOD, W'(7), W'(-2));
    send_op(iadc_pkg::CMD_DIV, MAX_VAL, MIN_VAL);
    send_op(iadc_pkg::CMD_MOD, MIN_VAL, MAX_VAL);
    send_op(iadc_pkg::CMD_DIV, W'(123), '0);       // divide by zero
    send_op(iadc_pkg::CMD_MOD, NEG_ONE, '0);       // modulo by zero
    send_op(3'd5, MAX_VAL, W'(1));                 // unknown commands
    send_op(3'd6, '0, '0);
    send_op(3'd7, NEG_ONE, NEG_ONE);
    drain();
  endtask

  task automatic test_random(int count, int idle_pct);
    send_idle_pct = idle_pct;
    repeat (count) begin
      send_op(3'($urandom_range(7)), pick_operand(), pick_operand());
    end
    send_idle_pct = 0;
  endtask

  // Results are accepted every cycle result_valid_o is high; compare each
  // against the oldest expectation.
  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result=%h status=%0d", result_o, status_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_count++;
        if (result_o !== exp_r.value) begin
          $error("result mismatch: expected %h, actual %h", exp_r.value, result_o);
          error_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_r.status, status_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles with neither a transaction taken nor a result delivered.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(350, 0);    // back to back
    test_random(300, 85);   // sparse sender
    drain();                // pause until the pipeline is empty
    test_random(300, 20);
    test_random(150, 0);
    drain();
    repeat (LATENCY + 5) @(posedge clk_i);
    $display("Covered %0d transactions, %0d results checked: all commands, zero divisors,",
             sent_count, checked_count);
    $display("overflow wraps and MIN/-1, with back-to-back and idle-heavy traffic.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
